[rtl/core/swa_pkg.sv]
// Shared types, widths and constants of the six-wheel arc target accumulator.
// Used by the controller, the datapath, the square-root unit and the top level.
`timescale 1ns / 1ps

package swa_pkg;

  localparam int MOTOR_COUNT          = 6;
  localparam int POSITION_WIDTH_DEF   = 40;
  localparam int OUT_W                = 40;

  localparam int CFG_W                = 24;
  localparam int CFG_IDX_W            = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_AXLE_TRACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_BASE = 2'd1;

  localparam int DIST_W               = 24;
  localparam int RADIUS_W             = 24;
  localparam int ANGLE_W              = 10;
  localparam int LEN9_W               = 26;
  localparam int KANG_W               = 28;
  localparam int ARC_W                = 30;
  localparam int ARC_SHIFT            = 25;
  localparam int MUL_W                = 32;
  localparam int PROD_W               = 64;
  localparam int RAD_W                = 52;
  localparam int ROOT_W               = 26;
  localparam int WHEEL_IDX_W          = 3;

  localparam logic [18:0] DEG_TO_RAD_Q24 = 19'd292818;

  typedef logic [2:0] mul_op_t;
  localparam mul_op_t MUL_KANG = 3'd0;
  localparam mul_op_t MUL_WBSQ = 3'd1;
  localparam mul_op_t MUL_SQ   = 3'd2;
  localparam mul_op_t MUL_MID  = 3'd3;
  localparam mul_op_t MUL_COR  = 3'd4;

  typedef struct packed {
    logic                   capture;
    logic                   mul_en;
    mul_op_t                mul_op;
    logic                   rsel;
    logic                   sqrt_start;
    logic                   wheel_upd;
    logic [WHEEL_IDX_W-1:0] wheel_idx;
    logic                   publish;
  } swa_cmd_t;

  typedef struct packed {
    logic is_turn;
    logic angle_zero;
    logic sqrt_done;
    logic publish_ok;
  } swa_stat_t;

endpackage

[rtl/core/six_wheel_arc_target_accumulator.sv]
// Top level of the six-wheel arc target accumulator: controller plus datapath.
// Depends on swa_pkg, swa_ctrl and swa_dp.
`timescale 1ns / 1ps

// The block takes one motion command at a time and returns all six wheel targets
// once per command. A straight command goes from dispatch to the wheel updates
// and a turn with zero angle goes from dispatch to publishing; a full turn runs
// through the bit-serial square root, which runs 26 steps once for each of the
// two radii, through the single shared multiplier, and through the saturating
// adder that visits the six wheels one per cycle. The next command is accepted in
// the cycle after the result has been loaded into the output register, which then
// holds it until the receiver takes it.
module six_wheel_arc_target_accumulator #(
  parameter int POSITION_WIDTH = swa_pkg::POSITION_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [swa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swa_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic signed [swa_pkg::DIST_W-1:0]   in_travel_distance,
  input  logic signed [swa_pkg::RADIUS_W-1:0] in_turn_radius,
  input  logic signed [swa_pkg::ANGLE_W-1:0]  in_turn_angle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [swa_pkg::OUT_W-1:0]    out_wheel0_position,
  output logic signed [swa_pkg::OUT_W-1:0]    out_wheel1_position,
  output logic signed [swa_pkg::OUT_W-1:0]    out_wheel2_position,
  output logic signed [swa_pkg::OUT_W-1:0]    out_wheel3_position,
  output logic signed [swa_pkg::OUT_W-1:0]    out_wheel4_position,
  output logic signed [swa_pkg::OUT_W-1:0]    out_wheel5_position
);
  import swa_pkg::*;

  swa_cmd_t         cmd;
  swa_stat_t        stat;
  logic [OUT_W-1:0] out_pos [MOTOR_COUNT];

  swa_ctrl u_swa_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  swa_dp #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_swa_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_opcode          (in_opcode),
    .in_travel_distance (in_travel_distance),
    .in_turn_radius     (in_turn_radius),
    .in_turn_angle      (in_turn_angle),
    .cmd                (cmd),
    .stat               (stat),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_pos            (out_pos)
  );

  assign out_wheel0_position = out_pos[0];
  assign out_wheel1_position = out_pos[1];
  assign out_wheel2_position = out_pos[2];
  assign out_wheel3_position = out_pos[3];
  assign out_wheel4_position = out_pos[4];
  assign out_wheel5_position = out_pos[5];

endmodule

[rtl/core/swa_sqrt.sv]
// Iterative integer square root, one result bit per cycle, rounded down.
// Depends on swa_pkg for the radicand and root widths.
`timescale 1ns / 1ps

module swa_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [swa_pkg::RAD_W-1:0]  radicand,
  output logic [swa_pkg::ROOT_W-1:0] root,
  output logic                       done
);
  import swa_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W+1:0]  rem_shift;
  logic [REM_W-1:0]  trial;
  logic              fits;
  logic [REM_W+1:0]  rem_diff;

  assign rem_shift = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial     = {root_r, 2'b01};
  assign fits      = rem_shift >= {2'b00, trial};
  assign rem_diff  = rem_shift - {2'b00, trial};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem_r  <= rem_diff[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_shift[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

[rtl/core/swa_dp.sv]
// Datapath: configuration, shared multiplier, arc registers, saturating wheel targets
// and the output register. Depends on swa_pkg and instantiates swa_sqrt.
`timescale 1ns / 1ps

module swa_dp #(
  parameter int POSITION_WIDTH = swa_pkg::POSITION_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [swa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_opcode,
  input  logic signed [swa_pkg::DIST_W-1:0]   in_travel_distance,
  input  logic signed [swa_pkg::RADIUS_W-1:0] in_turn_radius,
  input  logic signed [swa_pkg::ANGLE_W-1:0]  in_turn_angle,
  input  swa_pkg::swa_cmd_t             cmd,
  output swa_pkg::swa_stat_t            stat,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [swa_pkg::OUT_W-1:0]     out_pos [swa_pkg::MOTOR_COUNT]
);
  import swa_pkg::*;

  localparam int PW = POSITION_WIDTH;
  localparam logic [WHEEL_IDX_W-1:0] WHEEL_MID_LEFT  = WHEEL_IDX_W'(1);
  localparam logic [WHEEL_IDX_W-1:0] WHEEL_MID_RIGHT = WHEEL_IDX_W'(4);
  localparam logic [WHEEL_IDX_W-1:0] WHEEL_RIGHT_LO  = WHEEL_IDX_W'(3);
  localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

  logic [CFG_W-1:0]           axle_track_r;
  logic [CFG_W-1:0]           wheel_base_r;
  logic                       opcode_r;
  logic signed [DIST_W-1:0]   dist_r;
  logic signed [ANGLE_W-1:0]  ang_r;
  logic signed [LEN9_W-1:0]   inner9_r;
  logic signed [LEN9_W-1:0]   outer9_r;
  logic [KANG_W-1:0]          kang_r;
  logic [RAD_W-1:0]           wbsq_r;
  logic [RAD_W-1:0]           radicand_r;
  logic signed [ARC_W-1:0]    mid_in_r;
  logic signed [ARC_W-1:0]    mid_out_r;
  logic signed [ARC_W-1:0]    cor_in_r;
  logic signed [ARC_W-1:0]    cor_out_r;
  logic signed [PW-1:0]       target_r [MOTOR_COUNT];
  logic [OUT_W-1:0]           out_pos_r [MOTOR_COUNT];
  logic                       out_valid_r;

  logic signed [LEN9_W-1:0]   two_r;
  logic signed [LEN9_W-1:0]   track9;
  logic signed [LEN9_W-1:0]   len9;
  logic                       len_neg;
  logic [LEN9_W-1:0]          len_u;
  logic [LEN9_W-1:0]          len_mag;
  logic                       ang_neg;
  logic [ANGLE_W-1:0]         ang_u;
  logic [ANGLE_W-1:0]         ang_mag;
  logic [ROOT_W-1:0]          hyp;
  logic [MUL_W-1:0]           mul_a;
  logic [MUL_W-1:0]           mul_b;
  logic [PROD_W-1:0]          prod;
  logic [ARC_W-2:0]           arc_mag;
  logic                       arc_neg;
  logic signed [ARC_W-1:0]    arc_val;
  logic signed [ARC_W-1:0]    delta;
  logic                       use_outer;
  logic                       is_mid;
  logic signed [PW:0]         sum;
  logic signed [PW-1:0]       sat_sum;

  swa_sqrt u_swa_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (radicand_r),
    .root     (hyp),
    .done     (stat.sqrt_done)
  );

  assign two_r   = {in_turn_radius[RADIUS_W-1], in_turn_radius, 1'b0};
  assign track9  = {{(LEN9_W-CFG_W){1'b0}}, axle_track_r};

  assign len9    = cmd.rsel ? outer9_r : inner9_r;
  assign len_neg = len9[LEN9_W-1];
  assign len_u   = len9;
  assign len_mag = len_neg ? (LEN9_W'(0) - len_u) : len_u;

  assign ang_neg = ang_r[ANGLE_W-1];
  assign ang_u   = ang_r;
  assign ang_mag = ang_neg ? (ANGLE_W'(0) - ang_u) : ang_u;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    arc_neg = 1'b0;
    unique case (cmd.mul_op)
      MUL_KANG: begin
        mul_a = MUL_W'(ang_mag);
        mul_b = MUL_W'(DEG_TO_RAD_Q24);
      end
      MUL_WBSQ: begin
        mul_a = MUL_W'(wheel_base_r);
        mul_b = MUL_W'(wheel_base_r);
      end
      MUL_SQ: begin
        mul_a = MUL_W'(len_mag);
        mul_b = MUL_W'(len_mag);
      end
      MUL_MID: begin
        mul_a   = MUL_W'(kang_r);
        mul_b   = MUL_W'(len_mag);
        arc_neg = ang_neg ^ len_neg;
      end
      MUL_COR: begin
        mul_a   = MUL_W'(kang_r);
        mul_b   = MUL_W'(hyp);
        arc_neg = ang_neg;
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        arc_neg = 1'b0;
      end
    endcase
  end

  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign arc_mag = prod[ARC_SHIFT +: ARC_W-1];
  assign arc_val = arc_neg ? -$signed({1'b0, arc_mag}) : $signed({1'b0, arc_mag});

  // Right turns put the inner radius on wheels 3 to 5; left turns swap the sides.
  assign use_outer = (cmd.wheel_idx >= WHEEL_RIGHT_LO) ? ang_neg : !ang_neg;
  assign is_mid    = (cmd.wheel_idx == WHEEL_MID_LEFT) || (cmd.wheel_idx == WHEEL_MID_RIGHT);

  always_comb begin
    if (!opcode_r) begin
      delta = ARC_W'(dist_r);
    end else begin
      priority if (is_mid && use_outer) begin
        delta = mid_out_r;
      end else if (is_mid) begin
        delta = mid_in_r;
      end else if (use_outer) begin
        delta = cor_out_r;
      end else begin
        delta = cor_in_r;
      end
    end
  end

  assign sum = (PW+1)'(target_r[cmd.wheel_idx]) + (PW+1)'(delta);

  always_comb begin
    if (sum[PW] != sum[PW-1]) begin
      sat_sum = sum[PW] ? POS_MIN : POS_MAX;
    end else begin
      sat_sum = sum[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axle_track_r <= '0;
      wheel_base_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_AXLE_TRACK) begin
        axle_track_r <= cfg_data;
      end
      if (cfg_index == CFG_WHEEL_BASE) begin
        wheel_base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode_r <= in_opcode;
      dist_r   <= in_travel_distance;
      ang_r    <= in_turn_angle;
      inner9_r <= two_r - track9;
      outer9_r <= two_r + track9;
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_op)
        MUL_KANG: kang_r     <= prod[KANG_W-1:0];
        MUL_WBSQ: wbsq_r     <= prod[RAD_W-1:0];
        MUL_SQ:   radicand_r <= prod[RAD_W-1:0] + wbsq_r;
        MUL_MID: begin
          if (cmd.rsel) begin
            mid_out_r <= arc_val;
          end else begin
            mid_in_r <= arc_val;
          end
        end
        MUL_COR: begin
          if (cmd.rsel) begin
            cor_out_r <= arc_val;
          end else begin
            cor_in_r <= arc_val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        target_r[i] <= '0;
      end
    end else if (cmd.wheel_upd) begin
      target_r[cmd.wheel_idx] <= sat_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_out
    logic signed [PROD_W-1:0] pos_ext;
    assign pos_ext = PROD_W'(target_r[g]);
    always_ff @(posedge clk) begin
      if (cmd.publish) begin
        out_pos_r[g] <= pos_ext[OUT_W-1:0];
      end
    end
    assign out_pos[g] = out_pos_r[g];
  end

  assign out_valid       = out_valid_r;
  assign stat.is_turn    = opcode_r;
  assign stat.angle_zero = (ang_r == '0);
  assign stat.publish_ok = !out_valid_r || !out_stall;

endmodule

[rtl/core/swa_ctrl.sv]
// Controller state machine that sequences the multiplier, square root and wheel updates.
// Depends on swa_pkg for the command and status structs.
`timescale 1ns / 1ps

module swa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  swa_pkg::swa_stat_t stat,
  output swa_pkg::swa_cmd_t  cmd
);
  import swa_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_KANG      = 4'd2;
  localparam logic [3:0] S_WBSQ      = 4'd3;
  localparam logic [3:0] S_SQ        = 4'd4;
  localparam logic [3:0] S_ROOT_GO   = 4'd5;
  localparam logic [3:0] S_ROOT_WAIT = 4'd6;
  localparam logic [3:0] S_MID       = 4'd7;
  localparam logic [3:0] S_COR       = 4'd8;
  localparam logic [3:0] S_UPD       = 4'd9;
  localparam logic [3:0] S_PUB       = 4'd10;

  localparam logic [WHEEL_IDX_W-1:0] LAST_WHEEL = WHEEL_IDX_W'(MOTOR_COUNT - 1);

  logic [3:0]             state_r;
  logic [3:0]             state_nxt;
  logic                   rsel_r;
  logic                   rsel_nxt;
  logic [WHEEL_IDX_W-1:0] widx_r;
  logic [WHEEL_IDX_W-1:0] widx_nxt;

  always_comb begin
    state_nxt      = state_r;
    rsel_nxt       = rsel_r;
    widx_nxt       = widx_r;
    cmd            = '0;
    cmd.rsel       = rsel_r;
    cmd.wheel_idx  = widx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        rsel_nxt = 1'b0;
        widx_nxt = '0;
        priority if (!stat.is_turn) begin
          state_nxt = S_UPD;
        end else if (stat.angle_zero) begin
          state_nxt = S_PUB;
        end else begin
          state_nxt = S_KANG;
        end
      end
      S_KANG: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_KANG;
        state_nxt  = S_WBSQ;
      end
      S_WBSQ: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_WBSQ;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SQ;
        state_nxt  = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (stat.sqrt_done) begin
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_MID;
        state_nxt  = S_COR;
      end
      S_COR: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_COR;
        if (rsel_r) begin
          state_nxt = S_UPD;
        end else begin
          rsel_nxt  = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_UPD: begin
        cmd.wheel_upd = 1'b1;
        if (widx_r == LAST_WHEEL) begin
          state_nxt = S_PUB;
        end else begin
          widx_nxt = widx_r + 1'b1;
        end
      end
      S_PUB: begin
        if (stat.publish_ok) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rsel_r  <= 1'b0;
      widx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rsel_r  <= rsel_nxt;
      widx_r  <= widx_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[rtl/core/swa_checker.sv]
// Port-level checker for the six-wheel arc target accumulator, bound to the top level.
// Depends on swa_pkg for the output width.
`timescale 1ns / 1ps

module swa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [swa_pkg::OUT_W-1:0]   out_wheel0_position
);
  import swa_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Items accepted and not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken again in the cycle after an item was accepted");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending_r != 2'd0))
    else $error("result shown with no accepted item behind it");

  a_pending_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("more than two items outstanding or a result without an item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_wheel0_position)))
    else $error("stalled result dropped or changed");

endmodule

bind six_wheel_arc_target_accumulator swa_checker u_swa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_wheel0_position (out_wheel0_position)
);

[dv/wheel_target_sb_pkg.sv]
// Scoreboard for the six-wheel arc target accumulator: its own model of the wheel targets and
// the queue of expected outputs. Depends on swa_pkg for the register indexes.
`timescale 1ns / 1ps

package wheel_target_sb_pkg;

  typedef enum logic {
    MOVE_STRAIGHT  = 1'b0,
    TURN_BY_RADIUS = 1'b1
  } motion_op_t;

  typedef logic [5:0][39:0] wheel_set_t;

  localparam int WHEELS = 6;
  localparam longint unsigned RAD_PER_DEG_Q24 = 64'd292818;
  localparam int ARC_FRAC_SHIFT = 25;
  localparam longint POS_MAX = 64'sh0000_007F_FFFF_FFFF;
  localparam longint POS_MIN = -POS_MAX - 1;

  class wheel_target_scoreboard;
    longint axle_q8;
    longint base_q8;
    longint targets [WHEELS];
    wheel_set_t expected_q [$];
    int errors;

    function new();
      axle_q8 = 0;
      base_q8 = 0;
      errors = 0;
      foreach (targets[i]) targets[i] = 0;
    endfunction

    function void write_reg(logic [swa_pkg::CFG_IDX_W-1:0] index, logic [23:0] data);
      case (index)
        swa_pkg::CFG_AXLE_TRACK: axle_q8 = longint'(data);
        swa_pkg::CFG_WHEEL_BASE: base_q8 = longint'(data);
        default: ;
      endcase
    endfunction

    function longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Arc length in Q.8 for a length in Q.9, truncated toward zero.
    function longint arc_q8(longint angle, longint len9);
      longint unsigned p;
      longint q;
      bit neg;
      neg = (angle < 0) != (len9 < 0);
      p = magnitude(angle) * RAD_PER_DEG_Q24 * magnitude(len9);
      q = longint'(p >> ARC_FRAC_SHIFT);
      return neg ? -q : q;
    endfunction

    // Distance from the turn center to a corner wheel, Q.9, rounded down.
    function longint corner_q9(longint r9);
      longint unsigned a;
      longint unsigned b;
      a = magnitude(r9);
      b = longint'(base_q8);
      return longint'(root_floor(a * a + b * b));
    endfunction

    function void add_clamped(int idx, longint delta);
      longint p;
      p = targets[idx] + delta;
      if (p > POS_MAX) p = POS_MAX;
      else if (p < POS_MIN) p = POS_MIN;
      targets[idx] = p;
    endfunction

    function void note_command(motion_op_t op, logic signed [23:0] distance,
                               logic signed [23:0] radius, logic signed [9:0] angle);
      longint ang;
      longint inner9;
      longint outer9;
      longint near9;
      longint far9;
      longint cor_near;
      longint cor_far;
      wheel_set_t exp_set;
      ang = longint'(angle);
      if (op == MOVE_STRAIGHT) begin
        for (int i = 0; i < WHEELS; i++) add_clamped(i, longint'(distance));
      end else if (ang != 0) begin
        inner9 = 2 * longint'(radius) - axle_q8;
        outer9 = 2 * longint'(radius) + axle_q8;
        // Wheels 3 to 5 sit on the inner side of a right turn and the outer side of a left one.
        near9 = (ang > 0) ? inner9 : outer9;
        far9 = (ang > 0) ? outer9 : inner9;
        cor_near = arc_q8(ang, corner_q9(near9));
        cor_far = arc_q8(ang, corner_q9(far9));
        add_clamped(3, cor_near);
        add_clamped(4, arc_q8(ang, near9));
        add_clamped(5, cor_near);
        add_clamped(0, cor_far);
        add_clamped(1, arc_q8(ang, far9));
        add_clamped(2, cor_far);
      end
      for (int i = 0; i < WHEELS; i++) exp_set[i] = targets[i][39:0];
      expected_q.push_back(exp_set);
    endfunction

    function void check_result(wheel_set_t got);
      wheel_set_t exp_set;
      if (expected_q.size() == 0) begin
        $error("wheel positions arrived with no command outstanding");
        errors++;
        return;
      end
      exp_set = expected_q.pop_front();
      for (int i = 0; i < WHEELS; i++) begin
        if (got[i] !== exp_set[i]) begin
          $error("wheel%0d_position: expected %0d, actual %0d", i,
                 $signed(exp_set[i]), $signed(got[i]));
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit at_limits();
      return targets[3] == POS_MAX && targets[4] == POS_MIN;
    endfunction
  endclass

endpackage

[dv/tb_top.sv]
// Testbench top for the six-wheel arc target accumulator: clock, reset, command and
// configuration drivers, and the output sink. Depends on swa_pkg and wheel_target_sb_pkg.
`timescale 1ns / 1ps

module tb_top;
  import wheel_target_sb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [swa_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [swa_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [swa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [swa_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic in_opcode;
  logic signed [swa_pkg::DIST_W-1:0] in_travel_distance;
  logic signed [swa_pkg::RADIUS_W-1:0] in_turn_radius;
  logic signed [swa_pkg::ANGLE_W-1:0] in_turn_angle;
  logic out_valid;
  logic out_stall;
  logic signed [swa_pkg::OUT_W-1:0] out_wheel0_position;
  logic signed [swa_pkg::OUT_W-1:0] out_wheel1_position;
  logic signed [swa_pkg::OUT_W-1:0] out_wheel2_position;
  logic signed [swa_pkg::OUT_W-1:0] out_wheel3_position;
  logic signed [swa_pkg::OUT_W-1:0] out_wheel4_position;
  logic signed [swa_pkg::OUT_W-1:0] out_wheel5_position;

  wheel_target_scoreboard sb = new();
  int sent_count = 0;
  int cycle_count = 0;

  six_wheel_arc_target_accumulator uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_travel_distance  (in_travel_distance),
    .in_turn_radius      (in_turn_radius),
    .in_turn_angle       (in_turn_angle),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_wheel0_position (out_wheel0_position),
    .out_wheel1_position (out_wheel1_position),
    .out_wheel2_position (out_wheel2_position),
    .out_wheel3_position (out_wheel3_position),
    .out_wheel4_position (out_wheel4_position),
    .out_wheel5_position (out_wheel5_position)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_config(logic [23:0] axle, logic [23:0] base,
                              logic [swa_pkg::CFG_IDX_W-1:0] spare_index);
    logic [23:0] junk;
    junk = 24'($urandom);
    cfg_wr_en <= 1'b1;
    cfg_index <= swa_pkg::CFG_AXLE_TRACK;
    cfg_data <= axle;
    @(posedge clk);
    sb.write_reg(swa_pkg::CFG_AXLE_TRACK, axle);
    cfg_index <= swa_pkg::CFG_WHEEL_BASE;
    cfg_data <= base;
    @(posedge clk);
    sb.write_reg(swa_pkg::CFG_WHEEL_BASE, base);
    cfg_index <= spare_index;
    cfg_data <= junk;
    @(posedge clk);
    sb.write_reg(spare_index, junk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_command(motion_op_t op, logic signed [23:0] distance,
                              logic signed [23:0] radius, logic signed [9:0] angle);
    int gap;
    gap = (sent_count % 60 >= 45) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_travel_distance <= distance;
    in_turn_radius <= radius;
    in_turn_angle <= angle;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_command(op, distance, radius, angle);
    sent_count++;
  endtask

  task automatic send_random_command();
    int sel;
    motion_op_t op;
    logic signed [23:0] radius;
    logic signed [9:0] angle;
    sel = $urandom_range(0, 9);
    op = (sel < 4) ? MOVE_STRAIGHT : TURN_BY_RADIUS;
    radius = 24'($urandom);
    angle = 10'($urandom);
    if ($urandom_range(0, 1) == 1) radius = 24'(int'($urandom_range(0, 8192)) - 4096);
    if (sel == 9) angle = '0;
    else if (sel >= 6) angle = 10'(int'($urandom_range(0, 720)) - 360);
    send_command(op, 24'($urandom), radius, angle);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : result_sink
    int hold_left;
    int taken;
    int w;
    wheel_set_t got;
    hold_left = 0;
    taken = 0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got = {out_wheel5_position, out_wheel4_position, out_wheel3_position,
               out_wheel2_position, out_wheel1_position, out_wheel0_position};
        sb.check_result(got);
        taken++;
        if (taken == 150 || taken == 400) w = 300;
        else if (taken % 50 >= 35) w = 0;
        else w = $urandom_range(0, 6);
        if (w != 0) begin
          out_stall <= 1'b1;
          hold_left = w;
        end
      end else if (hold_left != 0) begin
        hold_left--;
        if (hold_left == 0) out_stall <= 1'b0;
      end
    end
  end

  initial begin : command_source
    logic [23:0] axle;
    logic [23:0] base;
    int ramp_count;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_opcode <= MOVE_STRAIGHT;
    in_travel_distance <= '0;
    in_turn_radius <= '0;
    in_turn_angle <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_config(24'h000300, 24'h000240, CFG_SPARE_2);
    send_command(MOVE_STRAIGHT, 24'sh7FFFFF, 24'($urandom), 10'($urandom));
    send_command(MOVE_STRAIGHT, 24'h800000, 24'($urandom), 10'($urandom));
    send_command(MOVE_STRAIGHT, 24'sh000000, 24'($urandom), 10'($urandom));
    send_command(MOVE_STRAIGHT, 24'hFFFFFF, 24'($urandom), 10'($urandom));
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'sh000A00, 10'sd0);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'sh000A00, 10'sd90);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'sh000A00, -10'sd90);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'sh000A00, 10'sd360);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'sh000A00, -10'sd360);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'sh000A00, 10'h1FF);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'sh000A00, 10'h200);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'sh000000, 10'sd45);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'sh000100, -10'sd30);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'h800000, 10'sd1);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'sh7FFFFF, -10'sd1);
    send_command(TURN_BY_RADIUS, 24'($urandom), -24'sd1280, -10'sd45);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'h800000, 10'h200);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'sh7FFFFF, 10'h1FF);
    send_command(TURN_BY_RADIUS, 24'($urandom), 24'($urandom), 10'sd0);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          axle = 24'h000000;
          base = 24'h000000;
        end
        1: begin
          axle = 24'hFFFFFF;
          base = 24'hFFFFFF;
        end
        2: begin
          axle = 24'hFFFFFF;
          base = 24'h000000;
        end
        3: begin
          axle = 24'h000000;
          base = 24'hFFFFFF;
        end
        4: begin
          axle = 24'($urandom_range(0, 4096));
          base = 24'($urandom_range(0, 4096));
        end
        default: begin
          axle = 24'($urandom);
          base = 24'($urandom);
        end
      endcase
      write_config(axle, base, (phase % 2 == 1) ? CFG_SPARE_3 : CFG_SPARE_2);
      repeat (90) send_random_command();
      settle();
    end

    // Push wheels 3 and 5 up and wheel 4 down with the largest turns, then back off.
    write_config(24'hFFFFFF, 24'hFFFFFF, CFG_SPARE_3);
    ramp_count = 0;
    while (!sb.at_limits() && ramp_count < 8) begin
      send_command(TURN_BY_RADIUS, 24'($urandom), 24'h800000, 10'h1FF);
      ramp_count++;
    end
    repeat (16) send_command(TURN_BY_RADIUS, 24'($urandom), 24'h800000, 10'h1FF);
    repeat (16) send_command(TURN_BY_RADIUS, 24'($urandom), 24'h800000, 10'h200);
    settle();

    write_config(24'($urandom), 24'($urandom), CFG_SPARE_2);
    repeat (40) send_random_command();
    settle();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
